// ----- src/lge_pkg.sv -----
// Shared types and constants for the life grid engine.
// No dependencies; imported by life_grid_engine_top.
package lge_pkg;

	// Field and register widths
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_W     = 3;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int NBR_W     = 4;

	// Grid size defaults
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_ROWS = 7'd64;
	localparam logic [CFG_W-1:0] RST_COLS = 7'd64;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd1;

	// Neighbor counts of the B3/S23 rule
	localparam logic [NBR_W-1:0] NBR_BIRTH = 4'd3;
	localparam logic [NBR_W-1:0] NBR_KEEP  = 4'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET     = 3'd0,
		CMD_CLEAR   = 3'd1,
		CMD_TOGGLE  = 3'd2,
		CMD_ADVANCE = 3'd3,
		CMD_READ    = 3'd4
	} lge_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDIT,
		ST_ADV_INIT,
		ST_ADV_FIRST,
		ST_ADV_ROW,
		ST_RESP
	} lge_state_t;

endpackage

// ----- src/life_grid_engine_top.sv -----
// Life grid engine: B3/S23 cell grid held one row per word in lge_ram.
// A rejected command or an advance with no rows goes straight to the response state. An edit
// or read reads its row on acceptance; in ST_EDIT an edit writes the modified row back. An advance
// primes the row window in ST_ADV_INIT and ST_ADV_FIRST, then writes one grid row per cycle. A
// new command is taken only in ST_IDLE, once the previous result has gone to the output register.
// Reset: control registers clear at once; a clearing pass writes MAX_ROWS zero rows, one per cycle.
module life_grid_engine_top
	import lge_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [ROW_W-1:0]     row,
	input  logic [COL_W-1:0]     col,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 cell_value,
	output logic                 status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int ROW_AW = $clog2(MAX_ROWS);
	localparam int COL_AW = $clog2(MAX_COLS);
	localparam int NR_W   = (ROW_AW + 2 > CFG_W) ? ROW_AW + 2 : CFG_W;
	localparam int NC_W   = (COL_AW + 1 > CFG_W) ? COL_AW + 1 : CFG_W;

	lge_state_t state_q, state_d;

	logic [CFG_W-1:0]    rows_q, cols_q;
	logic [NR_W-1:0]     nr;
	logic [NC_W-1:0]     nc;
	logic [MAX_COLS-1:0] colmask;

	logic [CMD_W-1:0]    cmd_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_AW-1:0]   clr_q;
	logic [NR_W-1:0]     adv_row_q;
	logic [NR_W-1:0]     adv_next1, adv_next2;
	logic                last_row;
	logic [MAX_COLS-1:0] above_q, cur_q;

	logic                res_value_q, res_status_q;
	logic                out_valid_q, out_value_q, out_status_q;
	logic                out_load;

	logic                in_accept, cfg_we, addr_ok, edit_cmd;

	logic                ram_we, ram_re;
	logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
	logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

	logic [COL_AW-1:0]   col_idx;
	logic                edit_old_bit, edit_new_bit;
	logic [MAX_COLS-1:0] edit_row;

	logic [MAX_COLS-1:0] above_m, cur_m, below_m;
	logic [MAX_COLS+1:0] above_p, cur_p, below_p;
	logic [NBR_W-1:0]    nbr [MAX_COLS];
	logic [MAX_COLS-1:0] life_row, merged_row;

	// Handshakes
	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	// Clamp the grid size to the storage
	assign nr = (NR_W'(rows_q) > NR_W'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : NR_W'(rows_q);
	assign nc = (NC_W'(cols_q) > NC_W'(MAX_COLS)) ? NC_W'(MAX_COLS) : NC_W'(cols_q);

	// Mark the columns in use
	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			colmask[j] = (NC_W'(j) < nc);
		end
	end

	// Classify the incoming command
	assign edit_cmd = cmd inside {CMD_SET, CMD_CLEAR, CMD_TOGGLE, CMD_READ};
	assign addr_ok  = (NR_W'(row) < nr) && (NC_W'(col) < nc);

	// Sweep row arithmetic
	assign adv_next1 = adv_row_q + NR_W'(1);
	assign adv_next2 = adv_row_q + NR_W'(2);
	assign last_row  = (adv_next1 == nr);

	// Modify one cell of the row word read back
	assign col_idx      = COL_AW'(col_q);
	assign edit_old_bit = ram_rdata[col_idx];

	always_comb begin
		case (cmd_q)
			CMD_SET:    edit_new_bit = 1'b1;
			CMD_CLEAR:  edit_new_bit = 1'b0;
			CMD_TOGGLE: edit_new_bit = ~edit_old_bit;
			default:    edit_new_bit = edit_old_bit;
		endcase
		edit_row          = ram_rdata;
		edit_row[col_idx] = edit_new_bit;
	end

	// Next generation of one row from the old rows above, at and below it
	assign above_m = above_q & colmask;
	assign cur_m   = cur_q & colmask;
	assign below_m = last_row ? '0 : (ram_rdata & colmask);
	assign above_p = {1'b0, above_m, 1'b0};
	assign cur_p   = {1'b0, cur_m, 1'b0};
	assign below_p = {1'b0, below_m, 1'b0};

	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			nbr[j] = NBR_W'(above_p[j]) + NBR_W'(above_p[j+1]) + NBR_W'(above_p[j+2])
				+ NBR_W'(cur_p[j]) + NBR_W'(cur_p[j+2])
				+ NBR_W'(below_p[j]) + NBR_W'(below_p[j+1]) + NBR_W'(below_p[j+2]);
			life_row[j]   = (nbr[j] == NBR_BIRTH) || ((nbr[j] == NBR_KEEP) && cur_m[j]);
			merged_row[j] = colmask[j] ? life_row[j] : cur_q[j];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ROW_AW'(MAX_ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					if (cmd == CMD_ADVANCE) begin
						state_d = (nr == '0) ? ST_RESP : ST_ADV_INIT;
					end else if (edit_cmd && addr_ok) begin
						state_d = ST_EDIT;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_EDIT:      state_d = ST_RESP;
			ST_ADV_INIT:  state_d = ST_ADV_FIRST;
			ST_ADV_FIRST: state_d = ST_ADV_ROW;
			ST_ADV_ROW: begin
				if (last_row) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM controls per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				ram_re    = in_accept && edit_cmd && addr_ok;
				ram_raddr = ROW_AW'(row);
			end
			ST_EDIT: begin
				ram_we    = (cmd_q != CMD_READ);
				ram_waddr = ROW_AW'(row_q);
				ram_wdata = edit_row;
			end
			ST_ADV_INIT: begin
				ram_re = 1'b1;
			end
			ST_ADV_FIRST: begin
				ram_re    = (NR_W'(1) < nr);
				ram_raddr = ROW_AW'(1);
			end
			ST_ADV_ROW: begin
				ram_we    = 1'b1;
				ram_waddr = adv_row_q[ROW_AW-1:0];
				ram_wdata = merged_row;
				ram_re    = (adv_next2 < nr);
				ram_raddr = adv_next2[ROW_AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rows_q      <= RST_ROWS;
			cols_q      <= RST_COLS;
			clr_q       <= '0;
			adv_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_IDX_ROWS: rows_q <= cfg_data;
					CFG_IDX_COLS: cols_q <= cfg_data;
					default:      rows_q <= rows_q;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ROW_AW'(1);
			end
			if (state_q == ST_ADV_FIRST) begin
				adv_row_q <= '0;
			end else if (state_q == ST_ADV_ROW) begin
				adv_row_q <= adv_next1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: command, row window and results
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q        <= cmd;
			row_q        <= row;
			col_q        <= col;
			res_value_q  <= 1'b0;
			res_status_q <= !((cmd == CMD_ADVANCE) || (edit_cmd && addr_ok));
		end
		if (state_q == ST_EDIT) begin
			res_value_q <= edit_new_bit;
		end
		if (state_q == ST_ADV_FIRST) begin
			above_q <= '0;
			cur_q   <= ram_rdata;
		end else if (state_q == ST_ADV_ROW) begin
			above_q <= cur_q;
			cur_q   <= ram_rdata;
		end
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = out_value_q;
	assign status     = out_status_q;

	lge_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_grid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The sweep never reads the row it writes back
	a_no_rw_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("grid RAM read and write hit the same row");

	// One command in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("command taken while another is in flight");

	// A result appears only out of the response state
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result presented without a finished command");

	// The sweep row stays inside the rows in use
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_ROW) |-> (adv_row_q < nr))
		else $error("advance sweep ran past the last row");

endmodule

// ----- src/lge_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
